// ----- hw/rtl/qoi_enc_pkg.sv -----
package qoi_enc_pkg;

    // Color index geometry.
    localparam int INDEX_DEPTH = 64;
    localparam int IDX_W       = $clog2(INDEX_DEPTH);

    // Output word buffer: a pending run byte plus the longest chunk.
    localparam int MAX_BYTES = 6;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);

    // Chunk opcodes.
    localparam logic [7:0] OP_INDEX = 8'h00;
    localparam logic [7:0] OP_DIFF  = 8'h40;
    localparam logic [7:0] OP_LUMA  = 8'h80;
    localparam logic [7:0] OP_RUN   = 8'hC0;
    localparam logic [7:0] OP_RGB   = 8'hFE;
    localparam logic [7:0] OP_RGBA  = 8'hFF;

    // A run is closed as soon as it reaches this length.
    localparam logic [5:0] RUN_MAX  = 6'd62;
    localparam logic [7:0] RUN_FULL = OP_RUN | {2'b00, RUN_MAX - 6'd1};

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } t_pixel;

    localparam t_pixel PIXEL_RESET = '{r: 8'h00, g: 8'h00, b: 8'h00, a: 8'hFF};

    // Contents of the input register stage, with the index entry read for it.
    typedef struct packed {
        logic             valid;
        logic             eoi;
        t_pixel           pix;
        logic [IDX_W-1:0] slot;
        t_pixel           entry;
    } t_s1;

    // Color index write request.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] slot;
        t_pixel           pix;
    } t_wr;

    // Bytes handed to the output serializer, first byte in element zero.
    typedef struct packed {
        logic [CNT_W-1:0]           cnt;
        logic [MAX_BYTES-1:0][7:0]  bytes;
    } t_load;

endpackage

// ----- hw/rtl/qoi_enc_if.sv -----
// Pixel channel: one RGBA pixel or an end-of-image mark per word.
interface qoi_enc_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       end_of_image;

    modport source (output valid, red, green, blue, alpha, end_of_image, input ready);
    modport sink   (input valid, red, green, blue, alpha, end_of_image, output ready);
endinterface

// Byte channel: one byte of the chunk stream per word.
interface qoi_enc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, out_byte, last_byte, input ready);
    modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

// ----- hw/rtl/qoi_pixel_encoder.sv -----
// QOI chunk encoder for a stream of RGBA pixels. Each pixel word passes an
// input register, where its hash slot is read from the 64-entry color index,
// and then the chunk logic, which loads the chunk bytes into an output
// serializer that moves one byte per cycle while the byte sink is ready. A word
// that produces no byte (a pixel that extends a run, or end of image with no
// run pending) leaves once the serializer can take a load; a word with bytes
// holds the next until its last byte is leaving, so a stream of one-byte chunks
// runs at one pixel per cycle while the sink is ready. The color index is
// cleared at reset at once by per-entry valid bits; no clearing pass is needed.
module qoi_pixel_encoder (
    input  logic            i_clk,
    input  logic            i_rst_n,
    qoi_enc_pix_if.sink     i_pix,
    qoi_enc_byte_if.source  o_byte
);
    import qoi_enc_pkg::*;

    t_s1   s1;
    t_wr   wr;
    t_load load;
    logic  can_load;
    logic  commit;

    // The staged word leaves when the serializer can take its bytes.
    assign commit = s1.valid && can_load;

    qoi_enc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pix    (i_pix),
        .i_commit (commit),
        .i_wr     (wr),
        .o_s1     (s1)
    );

    qoi_enc_chunk u_chunk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_s1     (s1),
        .i_commit (commit),
        .o_load   (load),
        .o_wr     (wr)
    );

    qoi_enc_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_commit   (commit),
        .i_load     (load),
        .o_can_load (can_load),
        .o_byte     (o_byte)
    );

endmodule

// ----- hw/rtl/qoi_enc_front.sv -----
module qoi_enc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    qoi_enc_pix_if.sink       i_pix,
    input  logic              i_commit,
    input  qoi_enc_pkg::t_wr  i_wr,
    output qoi_enc_pkg::t_s1  o_s1
);
    import qoi_enc_pkg::*;

    t_pixel           in_pix;
    logic [7:0]       hash_sum;
    logic [IDX_W-1:0] in_slot;
    logic             accept;
    logic             byp_hit;

    logic             r_valid;
    logic             r_eoi;
    t_pixel           r_pix;
    logic [IDX_W-1:0] r_slot;

    t_pixel           mem [INDEX_DEPTH];
    t_pixel           r_mem_q;
    logic [INDEX_DEPTH-1:0] r_vld;
    logic             r_rd_vld;
    logic             r_byp;
    t_pixel           r_byp_pix;

    assign in_pix = '{r: i_pix.red, g: i_pix.green, b: i_pix.blue, a: i_pix.alpha};

    // Hash slot; only the low bits of the sum matter, so 8-bit arithmetic suffices.
    assign hash_sum = in_pix.r * 8'd3 + in_pix.g * 8'd5 + in_pix.b * 8'd7 + in_pix.a * 8'd11;
    assign in_slot  = hash_sum[IDX_W-1:0];

    // The stage takes a new word when it is empty or its word leaves this cycle.
    assign i_pix.ready = !r_valid || i_commit;
    assign accept      = i_pix.valid && i_pix.ready;

    // The word leaving now may write the very slot the new word reads.
    assign byp_hit = i_wr.en && (i_wr.slot == in_slot);

    // Stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_valid <= i_pix.valid;
        end
    end

    // Stage payload and registered index read.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_eoi     <= i_pix.end_of_image;
            r_pix     <= in_pix;
            r_slot    <= in_slot;
            r_mem_q   <= mem[in_slot];
            r_rd_vld  <= r_vld[in_slot];
            r_byp     <= byp_hit;
            r_byp_pix <= i_wr.pix;
        end
    end

    // Index storage.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.slot] <= i_wr.pix;
        end
    end

    // Per-entry valid bits; an unwritten entry reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.slot] <= 1'b1;
        end
    end

    assign o_s1.valid = r_valid;
    assign o_s1.eoi   = r_eoi;
    assign o_s1.pix   = r_pix;
    assign o_s1.slot  = r_slot;
    assign o_s1.entry = r_byp ? r_byp_pix : (r_rd_vld ? r_mem_q : '0);

endmodule

// ----- hw/rtl/qoi_enc_chunk.sv -----
module qoi_enc_chunk (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  qoi_enc_pkg::t_s1    i_s1,
    input  logic                i_commit,
    output qoi_enc_pkg::t_load  o_load,
    output qoi_enc_pkg::t_wr    o_wr
);
    import qoi_enc_pkg::*;

    t_pixel       r_prev;
    logic [5:0]   r_run;
    t_pixel       n_prev;
    logic [5:0]   n_run;

    t_pixel       p;
    logic         same;
    logic [5:0]   run_inc;
    logic         pend;
    logic [7:0]   run_byte;

    logic signed [7:0] dr, dg, db;
    logic signed [8:0] drg, dbg;
    logic [7:0]   dr2, dg2, db2, dg32;
    logic [8:0]   drg8, dbg8;
    logic         is_diff, is_luma;

    logic [4:0][7:0]  c;
    logic [CNT_W-1:0] ccnt;

    assign p        = i_s1.pix;
    assign same     = (p == r_prev);
    assign run_inc  = r_run + 6'd1;
    assign pend     = (r_run != 6'd0);
    assign run_byte = OP_RUN | {2'b00, r_run - 6'd1};

    // Channel differences wrap into -128..127.
    assign dr   = signed'(p.r - r_prev.r);
    assign dg   = signed'(p.g - r_prev.g);
    assign db   = signed'(p.b - r_prev.b);
    assign drg  = signed'({dr[7], dr} - {dg[7], dg});
    assign dbg  = signed'({db[7], db} - {dg[7], dg});
    assign dr2  = dr + 8'sd2;
    assign dg2  = dg + 8'sd2;
    assign db2  = db + 8'sd2;
    assign dg32 = dg + 8'sd32;
    assign drg8 = drg + 9'sd8;
    assign dbg8 = dbg + 9'sd8;

    assign is_diff = (dr >= -8'sd2) && (dr <= 8'sd1) && (dg >= -8'sd2) && (dg <= 8'sd1)
                  && (db >= -8'sd2) && (db <= 8'sd1);
    assign is_luma = (dg >= -8'sd32) && (dg <= 8'sd31) && (drg >= -9'sd8) && (drg <= 9'sd7)
                  && (dbg >= -9'sd8) && (dbg <= 9'sd7);

    // Chunk selection for a pixel that differs from the previous one.
    always_comb begin
        c    = '0;
        ccnt = CNT_W'(1);
        priority if (i_s1.entry == p) begin
            c[0] = OP_INDEX | {2'b00, i_s1.slot};
        end else if (p.a != r_prev.a) begin
            c    = {p.a, p.b, p.g, p.r, OP_RGBA};
            ccnt = CNT_W'(5);
        end else if (is_diff) begin
            c[0] = OP_DIFF | {2'b00, dr2[1:0], dg2[1:0], db2[1:0]};
        end else if (is_luma) begin
            c[0] = OP_LUMA | {2'b00, dg32[5:0]};
            c[1] = {drg8[3:0], dbg8[3:0]};
            ccnt = CNT_W'(2);
        end else begin
            c[0] = OP_RGB;
            c[1] = p.r;
            c[2] = p.g;
            c[3] = p.b;
            ccnt = CNT_W'(4);
        end
    end

    // Bytes, index write and next state for the word in the stage.
    always_comb begin
        o_load = '0;
        o_wr   = '{en: 1'b0, slot: i_s1.slot, pix: p};
        n_prev = r_prev;
        n_run  = r_run;
        priority if (i_s1.eoi) begin
            n_run = 6'd0;
            if (pend) begin
                o_load.bytes[0] = run_byte;
                o_load.cnt      = CNT_W'(1);
            end
        end else if (same) begin
            if (run_inc == RUN_MAX) begin
                o_load.bytes[0] = RUN_FULL;
                o_load.cnt      = CNT_W'(1);
                n_run           = 6'd0;
            end else begin
                n_run = run_inc;
            end
        end else begin
            n_run   = 6'd0;
            n_prev  = p;
            o_wr.en = i_s1.valid;
            if (pend) begin
                o_load.bytes[0] = run_byte;
                for (int i = 1; i < MAX_BYTES; i++) begin
                    o_load.bytes[i] = c[i-1];
                end
                o_load.cnt = ccnt + CNT_W'(1);
            end else begin
                for (int i = 0; i < MAX_BYTES - 1; i++) begin
                    o_load.bytes[i] = c[i];
                end
                o_load.cnt = ccnt;
            end
        end
        if (!i_commit) begin
            o_wr.en = 1'b0;
        end
    end

    // Previous pixel and pending run advance when the word leaves the stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= PIXEL_RESET;
            r_run  <= 6'd0;
        end else if (i_commit) begin
            r_prev <= n_prev;
            r_run  <= n_run;
        end
    end

    // The pending run is always shorter than a full run.
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run < RUN_MAX)
        else $error("pending run reached full length");

    // End of image always leaves no pending run.
    a_eoi_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_commit && i_s1.eoi) |=> (r_run == 6'd0))
        else $error("run still pending after end of image");

    // An index write always makes the written pixel the previous pixel.
    a_wr_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.en |=> (r_prev == $past(o_wr.pix)))
        else $error("index write without previous pixel update");

    // Never more bytes than the buffer holds.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_commit |-> (o_load.cnt <= CNT_W'(MAX_BYTES)))
        else $error("chunk byte count out of range");

endmodule

// ----- hw/rtl/qoi_enc_emit.sv -----
module qoi_enc_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_commit,
    input  qoi_enc_pkg::t_load  i_load,
    output logic                o_can_load,
    qoi_enc_byte_if.source      o_byte
);
    import qoi_enc_pkg::*;

    logic [MAX_BYTES-1:0][7:0] r_buf;
    logic [CNT_W-1:0]          r_cnt;
    logic                      xfer;

    assign o_byte.valid     = (r_cnt != '0);
    assign o_byte.out_byte  = r_buf[0];
    assign o_byte.last_byte = (r_cnt == CNT_W'(1));
    assign xfer             = o_byte.valid && o_byte.ready;

    // New bytes may enter once the last buffered byte is leaving.
    assign o_can_load = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && o_byte.ready);

    // Byte count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_commit) begin
            r_cnt <= i_load.cnt;
        end else if (xfer) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Byte buffer shifts toward element zero as bytes leave.
    always_ff @(posedge i_clk) begin
        if (i_commit) begin
            r_buf <= i_load.bytes;
        end else if (xfer) begin
            r_buf <= {8'h00, r_buf[MAX_BYTES-1:1]};
        end
    end

    // Loading is only done over an empty or emptying buffer.
    a_load_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_commit |-> o_can_load)
        else $error("bytes loaded over undelivered bytes");

    // A non-empty load shows a byte in the next cycle.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_commit && (i_load.cnt != '0)) |=> o_byte.valid)
        else $error("loaded bytes not presented");

endmodule

// ----- tb/sv/tb_qoi_pixel_encoder.sv -----
module tb_qoi_pixel_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import qoi_enc_pkg::*;

    // Generous bound: every word can stall on both sides.
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 20;

    // One byte of the chunk stream as the encoder should produce it.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_due;

    logic i_clk;
    logic i_rst_n;

    qoi_enc_pix_if  pix_ch ();
    qoi_enc_byte_if byte_ch ();

    qoi_pixel_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_byte  (byte_ch)
    );

    // Encoder state as the testbench tracks it.
    t_pixel      enc_prev;
    t_pixel      enc_index [INDEX_DEPTH];
    int unsigned enc_run;

    t_byte_due   chunk_bytes_due [$];
    int unsigned mismatches;
    int unsigned src_gap_pct;
    int unsigned sink_stall_pct;

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hang or a lost byte ends the run here.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Some tests failed");
        $finish;
    end

    function automatic int unsigned hash_slot(t_pixel p);
        return (3 * p.r + 5 * p.g + 7 * p.b + 11 * p.a) % INDEX_DEPTH;
    endfunction

    // Channel difference wrapped into -128..127.
    function automatic int wrap_delta(logic [7:0] now, logic [7:0] was);
        logic [7:0] d;
        d = now - was;
        return int'($signed(d));
    endfunction

    function automatic t_pixel offset_pixel(t_pixel base, int dr, int dg, int db);
        t_pixel p;
        p   = base;
        p.r = base.r + 8'(dr);
        p.g = base.g + 8'(dg);
        p.b = base.b + 8'(db);
        return p;
    endfunction

    function automatic void reset_encoder_state();
        enc_prev = PIXEL_RESET;
        foreach (enc_index[i]) enc_index[i] = '0;
        enc_run = 0;
    endfunction

    // Works out the chunk bytes caused by one accepted word and queues them.
    function automatic void predict_chunk_bytes(t_pixel p, logic eoi);
        logic [7:0]  seq [$];
        int unsigned slot;
        int          dr, dg, db, drg, dbg;
        if (!eoi && p == enc_prev) begin
            // A repeat only grows the run; a full run is closed at once.
            enc_run++;
            if (enc_run >= RUN_MAX) begin
                seq.push_back(RUN_FULL);
                enc_run = 0;
            end
        end else begin
            if (enc_run != 0) begin
                seq.push_back(OP_RUN | 8'(enc_run - 1));
                enc_run = 0;
            end
            if (!eoi) begin
                slot = hash_slot(p);
                dr   = wrap_delta(p.r, enc_prev.r);
                dg   = wrap_delta(p.g, enc_prev.g);
                db   = wrap_delta(p.b, enc_prev.b);
                drg  = dr - dg;
                dbg  = db - dg;
                if (enc_index[slot] == p) begin
                    seq.push_back(OP_INDEX | 8'(slot));
                end else if (p.a != enc_prev.a) begin
                    seq.push_back(OP_RGBA);
                    seq.push_back(p.r);
                    seq.push_back(p.g);
                    seq.push_back(p.b);
                    seq.push_back(p.a);
                end else if (dr >= -2 && dr <= 1 && dg >= -2 && dg <= 1 &&
                             db >= -2 && db <= 1) begin
                    seq.push_back(OP_DIFF | 8'(((dr + 2) << 4) | ((dg + 2) << 2) | (db + 2)));
                end else if (dg >= -32 && dg <= 31 && drg >= -8 && drg <= 7 &&
                             dbg >= -8 && dbg <= 7) begin
                    seq.push_back(OP_LUMA | 8'(dg + 32));
                    seq.push_back(8'(((drg + 8) << 4) | (dbg + 8)));
                end else begin
                    seq.push_back(OP_RGB);
                    seq.push_back(p.r);
                    seq.push_back(p.g);
                    seq.push_back(p.b);
                end
                enc_index[slot] = p;
                enc_prev        = p;
            end
        end
        foreach (seq[i]) begin
            chunk_bytes_due.push_back('{data: seq[i], last: (i == seq.size() - 1)});
        end
    endfunction

    // Offers one word, with a random gap first, and returns at the edge that takes it.
    task automatic send_word(t_pixel p, logic eoi);
        while ($urandom_range(0, 99) < src_gap_pct) begin
            pix_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_ch.valid        <= 1'b1;
        pix_ch.red          <= p.r;
        pix_ch.green        <= p.g;
        pix_ch.blue         <= p.b;
        pix_ch.alpha        <= p.a;
        pix_ch.end_of_image <= eoi;
        do @(negedge i_clk); while (!pix_ch.ready);
        @(posedge i_clk);
        predict_chunk_bytes(p, eoi);
    endtask

    // Holds the pixel side off until every queued byte has come out.
    task automatic test_drain_pause();
        pix_ch.valid <= 1'b0;
        do @(posedge i_clk); while (chunk_bytes_due.size() != 0);
    endtask

    // Hand-picked words: reset state, every chunk kind and the range edges.
    task automatic test_directed_chunks();
        t_pixel p;
        send_word(PIXEL_RESET, 1'b0);                   // repeat of the reset pixel
        send_word('0, 1'b1);                            // end of image flushes that run
        send_word('1, 1'b1);                            // end of image with no run
        send_word('{r: 8'h00, g: 8'h00, b: 8'h00, a: 8'h00}, 1'b0);  // zero pixel hits
        send_word('{r: 8'hFF, g: 8'hFF, b: 8'hFF, a: 8'hFF}, 1'b0);  // alpha change
        send_word(PIXEL_RESET, 1'b0);                   // all deltas +1 across the wrap
        send_word('{r: 8'hFE, g: 8'hFE, b: 8'hFE, a: 8'hFF}, 1'b0);  // all deltas -2
        send_word(offset_pixel(enc_prev, 1, -2, 1), 1'b0);
        send_word('{r: 8'd10, g: 8'd20, b: 8'd30, a: 8'hFF}, 1'b0);  // plain RGB
        send_word('{r: 8'd48, g: 8'd51, b: 8'd53, a: 8'hFF}, 1'b0);  // LUMA dg, dr-dg top, db-dg bottom
        send_word('{r: 8'd8,  g: 8'd19, b: 8'd28, a: 8'hFF}, 1'b0);  // LUMA dg, dr-dg bottom, db-dg top
        send_word(offset_pixel(enc_prev, 32, 32, 32), 1'b0);         // green just out
        send_word(offset_pixel(enc_prev, 0, 10, 20), 1'b0);          // blue diff out
        send_word('{r: 8'hFF, g: 8'hFF, b: 8'hFF, a: 8'hFF}, 1'b0);  // index hit
        send_word('{r: 8'h00, g: 8'hFF, b: 8'h00, a: 8'h80}, 1'b0);
        // A pending run followed by a five-byte chunk gives the longest output.
        p = enc_prev;
        send_word(p, 1'b0);
        send_word(p, 1'b0);
        send_word('{r: 8'h01, g: 8'h02, b: 8'h03, a: 8'h04}, 1'b0);
        send_word('{r: 8'h02, g: 8'h03, b: 8'h04, a: 8'h04}, 1'b0);
        send_word('0, 1'b1);
    endtask

    // Runs at the length limit and one just under it.
    task automatic test_run_limit();
        t_pixel p;
        p = t_pixel'($urandom);
        send_word(p, 1'b0);
        repeat (62) send_word(p, 1'b0);
        repeat (61) send_word(p, 1'b0);
        send_word(offset_pixel(p, 1, 1, 1), 1'b0);
    endtask

    // Short runs closed by an end-of-image word carrying random pixel fields.
    task automatic test_eoi_flush();
        t_pixel p;
        repeat (6) begin
            p = t_pixel'($urandom);
            send_word(p, 1'b0);
            repeat ($urandom_range(0, 5)) send_word(p, 1'b0);
            send_word(t_pixel'($urandom), 1'b1);
        end
    endtask

    // Pixel stream mostly close to the previous pixel, so every chunk kind shows up.
    task automatic test_random_stream(int unsigned count);
        int unsigned sent;
        int unsigned kind;
        int unsigned len;
        int          dg;
        t_pixel      p;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 18) begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(55, 70)
                                                   : $urandom_range(1, 8);
                repeat (len) send_word(enc_prev, 1'b0);
                sent += len;
            end else begin
                if (kind < 38) begin
                    p = offset_pixel(enc_prev, int'($urandom_range(0, 3)) - 2,
                                     int'($urandom_range(0, 3)) - 2,
                                     int'($urandom_range(0, 3)) - 2);
                end else if (kind < 58) begin
                    dg = int'($urandom_range(0, 63)) - 32;
                    p  = offset_pixel(enc_prev, dg + int'($urandom_range(0, 17)) - 9, dg,
                                      dg + int'($urandom_range(0, 17)) - 9);
                end else if (kind < 70) begin
                    p = enc_index[$urandom_range(0, INDEX_DEPTH - 1)];
                end else if (kind < 80) begin
                    p   = offset_pixel(enc_prev, int'($urandom_range(0, 3)) - 2, 0, 0);
                    p.a = 8'($urandom);
                end else begin
                    p = t_pixel'($urandom);
                end
                send_word(p, (kind >= 94));
                sent++;
            end
        end
    endtask

    // Byte sink with random backpressure.
    always @(posedge i_clk) begin
        byte_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Every byte taken is compared with the oldest one still due.
    always @(posedge i_clk) begin
        t_byte_due want;
        if (i_rst_n && byte_ch.valid && byte_ch.ready) begin
            if (chunk_bytes_due.size() == 0) begin
                $display("%0t: unexpected byte: expected none, actual %02h last %0b",
                         $time, byte_ch.out_byte, byte_ch.last_byte);
                mismatches++;
            end else begin
                want = chunk_bytes_due.pop_front();
                if (byte_ch.out_byte !== want.data) begin
                    $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                             $time, want.data, byte_ch.out_byte);
                    mismatches++;
                end
                if (byte_ch.last_byte !== want.last) begin
                    $display("%0t: last_byte mismatch: expected %0b, actual %0b",
                             $time, want.last, byte_ch.last_byte);
                    mismatches++;
                end
            end
        end
    end

    // Test sequence.
    initial begin
        i_rst_n             = 1'b0;
        pix_ch.valid        = 1'b0;
        pix_ch.red          = '0;
        pix_ch.green        = '0;
        pix_ch.blue         = '0;
        pix_ch.alpha        = '0;
        pix_ch.end_of_image = 1'b0;
        mismatches          = 0;
        src_gap_pct         = 36;
        sink_stall_pct      = 47;
        reset_encoder_state();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_chunks();
        test_run_limit();
        test_random_stream(110);
        test_drain_pause();

        src_gap_pct    = 47;
        sink_stall_pct = 36;
        test_eoi_flush();
        test_random_stream(110);

        src_gap_pct    = 0;
        sink_stall_pct = 0;
        test_random_stream(110);
        test_eoi_flush();

        test_drain_pause();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
